// File: hdl/fcfs_pkg.sv
package fcfs_pkg;

    // field widths of one job and of one result
    localparam int ARR_W      = 16;
    localparam int BUR_W      = 16;
    localparam int JOBNUM_W   = 7;
    localparam int WAIT_W     = 22;
    localparam int SUM_W      = 28;

    // default batch capacity
    localparam int MAX_JOBS_DEF = 64;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SCH_START,
        ST_SCH_RUN
    } fcfs_state_t;

endpackage

// File: hdl/fcfs_job_ram.sv
module fcfs_job_ram
    import fcfs_pkg::*;
#(
    parameter int DEPTH  = MAX_JOBS_DEF,
    parameter int DATA_W = ARR_W + BUR_W + $clog2(MAX_JOBS_DEF)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] job_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            job_mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= job_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/fcfs_schedule_metrics.sv
// Loading: a job into an empty or a full store is done in ST_IDLE alone (a full store drops
// it); otherwise the insertion walk reads and shifts up one slot each stored job with a later
// arrival, and writes the new job into the freed slot in ST_INS_CMP or ST_INS_PUT, through the
// job memory's write port and registered read port. Scheduling issues its first read in
// ST_SCH_START, then gives one result per cycle while out_ready is high, one memory read per result.
// Reset clears the sequencer, job count, overflow flag, clock and running totals;
// the job memory is not cleared and needs no clearing pass.
module fcfs_schedule_metrics
    import fcfs_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ARR_W-1:0]    arrival,
    input  logic [BUR_W-1:0]    burst,
    input  logic                last_job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [JOBNUM_W-1:0] job_number,
    output logic [ARR_W-1:0]    job_arrival,
    output logic [BUR_W-1:0]    job_burst,
    output logic [WAIT_W-1:0]   waiting,
    output logic [WAIT_W-1:0]   turnaround,
    output logic [SUM_W-1:0]    total_waiting,
    output logic [SUM_W-1:0]    total_turnaround,
    output logic                overflowed,
    output logic                final_result
);

    localparam int IDX_W  = $clog2(MAX_JOBS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CT_W   = ARR_W + $clog2(MAX_JOBS + 2);
    localparam int DATA_W = ARR_W + BUR_W + IDX_W;
    localparam int NUM_XW = IDX_W + JOBNUM_W;
    localparam int MET_XW = CT_W + SUM_W;

    fcfs_state_t state_reg, state_next;

    logic [CNT_W-1:0] job_count_reg, job_count_next;
    logic             overflow_reg, overflow_next;
    logic [CT_W-1:0]  ct_reg, ct_next;
    logic [SUM_W-1:0] sum_w_reg, sum_w_next;
    logic [SUM_W-1:0] sum_t_reg, sum_t_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [ARR_W-1:0] arr_reg, arr_next;
    logic [BUR_W-1:0] bur_reg, bur_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;

    logic [JOBNUM_W-1:0] job_number_reg;
    logic [ARR_W-1:0]    job_arrival_reg;
    logic [BUR_W-1:0]    job_burst_reg;
    logic [WAIT_W-1:0]   waiting_reg;
    logic [WAIT_W-1:0]   turnaround_reg;
    logic [SUM_W-1:0]    total_waiting_reg;
    logic [SUM_W-1:0]    total_turnaround_reg;
    logic                overflowed_reg;
    logic                final_result_reg;

    // memory port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [ARR_W-1:0]  rd_arr;
    logic [BUR_W-1:0]  rd_bur;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] new_entry;

    // metrics datapath
    logic [CT_W-1:0]   start_time;
    logic [CT_W-1:0]   wait_val;
    logic [CT_W-1:0]   turn_val;
    logic [CT_W-1:0]   ct_after;
    logic [MET_XW-1:0] wait_x;
    logic [MET_XW-1:0] turn_x;
    logic [SUM_W-1:0]  sum_w_add;
    logic [SUM_W-1:0]  sum_t_add;
    logic [NUM_XW-1:0] num_x;
    logic              is_final;
    logic              out_load;

    fcfs_job_ram #(
        .DEPTH  (MAX_JOBS),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_arr    = ram_rdata[DATA_W-1 -: ARR_W];
    assign rd_bur    = ram_rdata[IDX_W +: BUR_W];
    assign rd_idx    = ram_rdata[IDX_W-1:0];
    assign new_entry = {arr_reg, bur_reg, job_count_reg[IDX_W-1:0]};

    // serve the job read from memory: idle machine jumps to its arrival
    always_comb
    begin
        if (ct_reg < CT_W'(rd_arr))
        begin
            start_time = CT_W'(rd_arr);
        end
        else
        begin
            start_time = ct_reg;
        end
        wait_val  = start_time - CT_W'(rd_arr);
        turn_val  = wait_val + CT_W'(rd_bur);
        ct_after  = start_time + CT_W'(rd_bur);
        wait_x    = {{SUM_W{1'b0}}, wait_val};
        turn_x    = {{SUM_W{1'b0}}, turn_val};
        sum_w_add = sum_w_reg + wait_x[SUM_W-1:0];
        sum_t_add = sum_t_reg + turn_x[SUM_W-1:0];
        num_x     = {{JOBNUM_W{1'b0}}, rd_idx} + NUM_XW'(1);
        is_final  = (({1'b0, k_reg} + CNT_W'(1)) == job_count_reg);
    end

    // sequencer: sorted insertion walk, then service order readout
    always_comb
    begin
        state_next     = state_reg;
        job_count_next = job_count_reg;
        overflow_next  = overflow_reg;
        ct_next        = ct_reg;
        sum_w_next     = sum_w_reg;
        sum_t_next     = sum_t_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        arr_next       = arr_reg;
        bur_next       = bur_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = new_entry;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        in_ready       = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    arr_next  = arrival;
                    bur_next  = burst;
                    last_next = last_job;
                    if (job_count_reg == CNT_W'(MAX_JOBS))
                    begin
                        // batch full: drop the item
                        overflow_next = 1'b1;
                        if (last_job)
                        begin
                            state_next = ST_SCH_START;
                        end
                    end
                    else if (job_count_reg == '0)
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = '0;
                        ram_wdata      = {arrival, burst, {IDX_W{1'b0}}};
                        job_count_next = CNT_W'(1);
                        if (last_job)
                        begin
                            state_next = ST_SCH_START;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = job_count_reg[IDX_W-1:0] - IDX_W'(1);
                        pos_next   = job_count_reg[IDX_W-1:0];
                        state_next = ST_INS_CMP;
                    end
                end
            end

            ST_INS_CMP:
            begin
                if (rd_arr > arr_reg)
                begin
                    // shift the later job up one slot
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - IDX_W'(1);
                    if (pos_reg > IDX_W'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg - IDX_W'(2);
                    end
                    else
                    begin
                        state_next = ST_INS_PUT;
                    end
                end
                else
                begin
                    ram_we         = 1'b1;
                    job_count_next = job_count_reg + CNT_W'(1);
                    state_next     = last_reg ? ST_SCH_START : ST_IDLE;
                end
            end

            ST_INS_PUT:
            begin
                ram_we         = 1'b1;
                job_count_next = job_count_reg + CNT_W'(1);
                state_next     = last_reg ? ST_SCH_START : ST_IDLE;
            end

            ST_SCH_START:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                k_next     = '0;
                state_next = ST_SCH_RUN;
            end

            ST_SCH_RUN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    ct_next    = ct_after;
                    sum_w_next = sum_w_add;
                    sum_t_next = sum_t_add;
                    if (is_final)
                    begin
                        // batch done: clear for the next one
                        job_count_next = '0;
                        overflow_next  = 1'b0;
                        ct_next        = '0;
                        sum_w_next     = '0;
                        sum_t_next     = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        k_next    = k_reg + IDX_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = k_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register valid
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_count_reg <= '0;
            overflow_reg  <= 1'b0;
            ct_reg        <= '0;
            sum_w_reg     <= '0;
            sum_t_reg     <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            overflow_reg  <= overflow_next;
            ct_reg        <= ct_next;
            sum_w_reg     <= sum_w_next;
            sum_t_reg     <= sum_t_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        arr_reg <= arr_next;
        bur_reg <= bur_next;
        if (out_load)
        begin
            job_number_reg       <= num_x[JOBNUM_W-1:0];
            job_arrival_reg      <= rd_arr;
            job_burst_reg        <= rd_bur;
            waiting_reg          <= wait_x[WAIT_W-1:0];
            turnaround_reg       <= turn_x[WAIT_W-1:0];
            total_waiting_reg    <= sum_w_add;
            total_turnaround_reg <= sum_t_add;
            overflowed_reg       <= overflow_reg;
            final_result_reg     <= is_final;
        end
    end

    // sums seen on the result are the pre-clear totals
    assign out_valid        = out_valid_reg;
    assign job_number       = job_number_reg;
    assign job_arrival      = job_arrival_reg;
    assign job_burst        = job_burst_reg;
    assign waiting          = waiting_reg;
    assign turnaround       = turnaround_reg;
    assign total_waiting    = total_waiting_reg;
    assign total_turnaround = total_turnaround_reg;
    assign overflowed       = overflowed_reg;
    assign final_result     = final_result_reg;

    // job count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        job_count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count above capacity");

    // insertion slot stays between slot 1 and the first free slot of the store
    a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_CMP) |-> (pos_reg != '0 && {1'b0, pos_reg} <= job_count_reg))
        else $error("insertion slot out of range");

    // readout index stays below the job count
    a_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCH_RUN) |-> ({1'b0, k_reg} < job_count_reg))
        else $error("readout index out of range");

    // last result of a batch returns the block to an empty batch
    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_final) |=>
            (state_reg == ST_IDLE && job_count_reg == '0 && ct_reg == '0 && !overflow_reg))
        else $error("batch state not cleared");

endmodule
